@@ rtl/core/lpfd_pkg.sv @@
// Package: shared types, constants and helpers of the length-prefixed frame deframer.
package lpfd_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam logic [31:0] HDR_LEN      = 32'(HEADER_BYTES);
  localparam logic [31:0] LEN_FIELD_LO = 32'd4;
  localparam logic [31:0] LEN_FIELD_HI = 32'd8;

  localparam logic [15:0] MIN_LEN_ORIG = 16'd22;
  localparam logic [15:0] MIN_LEN_RESP = 16'd16;

  localparam logic [15:0] SIG_A = 16'h1111;
  localparam logic [15:0] SIG_B = 16'h2222;
  localparam logic [15:0] SIG_C = 16'h3333;
  localparam logic [15:0] SIG_D = 16'h5555;
  localparam logic [15:0] SIG_E = 16'h7777;
  localparam logic [15:0] SIG_F = 16'h9999;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam logic [0:0]  REG_IS_ORIG  = 1'b0;
  localparam logic [0:0]  REG_MAX_LEN  = 1'b1;
  localparam logic [31:0] MAX_LEN_RST  = 32'd65536;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_LOSS  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] delivery_length;
    logic        endpoint_established;
    logic        had_gap;
    logic [15:0] signature_word;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic        byte_in_frame;
    logic [31:0] frame_offset;
    logic        frame_end;
    logic [31:0] frame_length;
    logic        length_error;
    logic        delivery_skipped;
  } result_t;

  typedef struct packed {
    logic        is_originator;
    logic [31:0] max_frame_bytes;
  } cfg_t;

  // handshake between the pipeline stages
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

  function automatic logic sig_ok(input logic [15:0] w);
    sig_ok = (w == SIG_A) || (w == SIG_B) || (w == SIG_C) ||
             (w == SIG_D) || (w == SIG_E) || (w == SIG_F);
  endfunction

endpackage

@@ rtl/core/lpfd_in_if.sv @@
// Interface: input word channel of the deframer.
interface lpfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] delivery_length;
  logic        endpoint_established;
  logic        had_gap;
  logic [15:0] signature_word;
  logic [7:0]  data_byte;

  modport source (output valid, mode, delivery_length, endpoint_established, had_gap,
                  signature_word, data_byte, input ready);
  modport sink (input valid, mode, delivery_length, endpoint_established, had_gap,
                signature_word, data_byte, output ready);
endinterface

@@ rtl/core/lpfd_out_if.sv @@
// Interface: result word channel of the deframer.
interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic        byte_in_frame;
  logic [31:0] frame_offset;
  logic        frame_end;
  logic [31:0] frame_length;
  logic        length_error;
  logic        delivery_skipped;

  modport source (output valid, byte_in_frame, frame_offset, frame_end, frame_length,
                  length_error, delivery_skipped, input ready);
  modport sink (input valid, byte_in_frame, frame_offset, frame_end, frame_length,
                length_error, delivery_skipped, output ready);
endinterface

@@ rtl/core/lpfd_cfg_regs.sv @@
// Configuration registers with APB-style write and read.
module lpfd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output lpfd_pkg::cfg_t                 cfg
);

  logic        is_orig_r;
  logic [31:0] max_len_r;
  logic        wr_en;
  logic [0:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_orig_r <= 1'b1;
      max_len_r <= lpfd_pkg::MAX_LEN_RST;
    end else if (wr_en) begin
      unique case (idx)
        lpfd_pkg::REG_IS_ORIG: is_orig_r <= pwdata[0];
        lpfd_pkg::REG_MAX_LEN: max_len_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lpfd_pkg::REG_IS_ORIG: prdata = {31'b0, is_orig_r};
      lpfd_pkg::REG_MAX_LEN: prdata = max_len_r;
      default:               prdata = '0;
    endcase
  end

  assign cfg.is_originator   = is_orig_r;
  assign cfg.max_frame_bytes = max_len_r;

endmodule

@@ rtl/core/lpfd_in_stage.sv @@
// Input register stage: captures one word whenever the stage is free or moving on.
module lpfd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpfd_pkg::item_t     in_item,
  input  logic                advance,
  output logic                s1_valid,
  output lpfd_pkg::item_t     s1_item
);

  logic            valid_r;
  lpfd_pkg::item_t item_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

@@ rtl/core/lpfd_core.sv @@
// Deframer state and per-word decision logic.
module lpfd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  lpfd_pkg::cfg_t      cfg,
  input  lpfd_pkg::stage_ctl_t ctl,
  input  lpfd_pkg::item_t     item,
  output lpfd_pkg::result_t   res
);

  logic        pend_r,    pend_nxt;
  logic        decided_r, decided_nxt;
  logic        skip_r,    skip_nxt;
  logic [31:0] held_r,    held_nxt;
  logic [31:0] mlen_r,    mlen_nxt;

  logic        pend_eff;
  logic [15:0] min_len;
  logic [31:0] held_inc;
  logic [31:0] mlen_hdr;
  logic        bad_len;

  assign min_len  = cfg.is_originator ? lpfd_pkg::MIN_LEN_ORIG : lpfd_pkg::MIN_LEN_RESP;
  assign held_inc = held_r + 32'd1;
  assign pend_eff = decided_r ? pend_r : !item.endpoint_established;
  assign mlen_hdr = (held_r >= lpfd_pkg::LEN_FIELD_LO && held_r < lpfd_pkg::LEN_FIELD_HI)
                    ? {mlen_r[23:0], item.data_byte} : mlen_r;
  assign bad_len  = (mlen_hdr < lpfd_pkg::HDR_LEN) ||
                    ((mlen_hdr > lpfd_pkg::HDR_LEN) && (mlen_hdr > cfg.max_frame_bytes));

  always_comb begin
    pend_nxt    = pend_r;
    decided_nxt = decided_r;
    skip_nxt    = skip_r;
    held_nxt    = held_r;
    mlen_nxt    = mlen_r;
    res         = '0;
    unique case (lpfd_pkg::mode_t'(item.mode))
      lpfd_pkg::MODE_START: begin
        decided_nxt = 1'b1;
        pend_nxt    = pend_eff;
        if (item.had_gap) begin
          skip_nxt = 1'b1;
        end else if (held_r == 32'd0 && pend_eff) begin
          if (item.delivery_length < min_len || !lpfd_pkg::sig_ok(item.signature_word)) begin
            skip_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            skip_nxt = 1'b0;
          end
        end else begin
          skip_nxt = 1'b0;
        end
        res.delivery_skipped = skip_nxt;
      end
      lpfd_pkg::MODE_BYTE: begin
        if (!skip_r) begin
          res.byte_in_frame = 1'b1;
          res.frame_offset  = held_r;
          held_nxt          = held_inc;
          if (held_r < lpfd_pkg::HDR_LEN) begin
            mlen_nxt = mlen_hdr;
            if (held_inc == lpfd_pkg::HDR_LEN) begin
              res.frame_length = mlen_hdr;
              if (bad_len) begin
                res.length_error = 1'b1;
                held_nxt         = '0;
                mlen_nxt         = '0;
                pend_nxt         = 1'b1;
                skip_nxt         = 1'b1;
              end else if (mlen_hdr == lpfd_pkg::HDR_LEN) begin
                res.frame_end = 1'b1;
                held_nxt      = '0;
                mlen_nxt      = '0;
              end
            end
          end else begin
            res.frame_length = mlen_r;
            if (held_inc >= mlen_r) begin
              res.frame_end = 1'b1;
              held_nxt      = '0;
              mlen_nxt      = '0;
            end
          end
        end
      end
      lpfd_pkg::MODE_LOSS: begin
        held_nxt = '0;
        mlen_nxt = '0;
        pend_nxt = 1'b1;
        skip_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b1;
      decided_r <= 1'b0;
      skip_r    <= 1'b0;
      held_r    <= '0;
      mlen_r    <= '0;
    end else if (ctl.valid && ctl.advance) begin
      pend_r    <= pend_nxt;
      decided_r <= decided_nxt;
      skip_r    <= skip_nxt;
      held_r    <= held_nxt;
      mlen_r    <= mlen_nxt;
    end
  end

endmodule

@@ rtl/core/lpfd_out_stage.sv @@
// Result register stage: holds one result word until the sink takes it.
module lpfd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  lpfd_pkg::result_t res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfd_pkg::result_t out_res
);

  logic              valid_r;
  lpfd_pkg::result_t res_r;

  assign advance = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ rtl/core/length_prefixed_frame_deframer_top.sv @@
// Top level of the length-prefixed frame deframer.
//
//   channel  | dir | handshake          | words
//   in_ch    | in  | valid/ready        | mode, length, flags, signature, byte
//   out_ch   | out | valid/ready        | frame position, end, length, errors
//   cfg_*    | in  | APB, pready high   | is_originator @0, max_frame_bytes @4
//
// One word per cycle unless out_ch stalls; a word passes the input, then the result register.
// The per-word state update (byte counter, length compare) is combinational in the core.
// Reset is synchronous, active low, and needs no clearing pass.
// A stalled result holds its register; the input stage keeps taking words until full.
module length_prefixed_frame_deframer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  lpfd_in_if.sink                         in_ch,
  lpfd_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lpfd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  lpfd_pkg::cfg_t       cfg;
  lpfd_pkg::item_t      in_item;
  lpfd_pkg::item_t      s1_item;
  lpfd_pkg::result_t    res;
  lpfd_pkg::result_t    out_res;
  lpfd_pkg::stage_ctl_t ctl;

  assign in_item.mode                 = in_ch.mode;
  assign in_item.delivery_length      = in_ch.delivery_length;
  assign in_item.endpoint_established = in_ch.endpoint_established;
  assign in_item.had_gap              = in_ch.had_gap;
  assign in_item.signature_word       = in_ch.signature_word;
  assign in_item.data_byte            = in_ch.data_byte;

  lpfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lpfd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .advance  (ctl.advance),
    .s1_valid (ctl.valid),
    .s1_item  (s1_item)
  );

  lpfd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .ctl   (ctl),
    .item  (s1_item),
    .res   (res)
  );

  lpfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (ctl.valid),
    .res       (res),
    .advance   (ctl.advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.byte_in_frame    = out_res.byte_in_frame;
  assign out_ch.frame_offset     = out_res.frame_offset;
  assign out_ch.frame_end        = out_res.frame_end;
  assign out_ch.frame_length     = out_res.frame_length;
  assign out_ch.length_error     = out_res.length_error;
  assign out_ch.delivery_skipped = out_res.delivery_skipped;

endmodule

@@ rtl/core/lpfd_checker.sv @@
// Port-level assertions for the deframer and their bind to the top level.
module lpfd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_frame_end,
  input logic [31:0]                     out_frame_offset,
  input logic [31:0]                     out_frame_length,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic [lpfd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [31:0]                     cfg_pwdata,
  input logic [31:0]                     cfg_prdata
);

  logic in_fire;
  logic max_wr;

  assign in_fire = in_valid && in_ready;
  assign max_wr  = cfg_psel && cfg_penable && cfg_pwrite &&
                   (cfg_paddr[2:2] == lpfd_pkg::REG_MAX_LEN);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_offset) &&
                               $stable(out_frame_length) && $stable(out_frame_end))
    else $error("result word changed while stalled");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_fire, 2))
    else $error("result word without an accepted input word");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |->
      ({1'b0, out_frame_offset} + 33'd1 == {1'b0, out_frame_length}))
    else $error("frame end not on last byte of frame");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    max_wr ##1 (cfg_psel && !cfg_pwrite && (cfg_paddr[2:2] == lpfd_pkg::REG_MAX_LEN))
      |-> cfg_prdata == $past(cfg_pwdata))
    else $error("max length readback mismatch");

endmodule

bind length_prefixed_frame_deframer_top lpfd_checker u_lpfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_frame_end    (out_ch.frame_end),
  .out_frame_offset (out_ch.frame_offset),
  .out_frame_length (out_ch.frame_length),
  .cfg_psel         (cfg_psel),
  .cfg_penable      (cfg_penable),
  .cfg_pwrite       (cfg_pwrite),
  .cfg_paddr        (cfg_paddr),
  .cfg_pwdata       (cfg_pwdata),
  .cfg_prdata       (cfg_prdata)
);

@@ dv/deframer_checker.sv @@
// Checker for the deframer: predicts every result word from the accepted input words and compares.
module deframer_checker
  import lpfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lpfd_in_if                    in_mon,
  lpfd_out_if                   out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output int unsigned           fail_count,
  output int unsigned           results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        dir_orig;
  logic [31:0] len_limit;
  logic        resync_wait;
  logic        first_seen;
  logic        drop_delivery;
  logic [31:0] frame_pos;
  logic [31:0] hdr_len;

  result_t results_due[$];

  function automatic bit sig_known(input logic [15:0] w);
    case (w)
      SIG_A, SIG_B, SIG_C, SIG_D, SIG_E, SIG_F: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t deframe_word(input item_t w);
    result_t     r;
    logic [15:0] need;
    r = '0;
    need = dir_orig ? MIN_LEN_ORIG : MIN_LEN_RESP;
    case (w.mode)
      MODE_START: begin
        if (!first_seen) begin
          first_seen  = 1'b1;
          resync_wait = !w.endpoint_established;
        end
        if (w.had_gap) begin
          drop_delivery = 1'b1;
        end else if (frame_pos == 32'd0 && resync_wait) begin
          if (w.delivery_length < need || !sig_known(w.signature_word)) begin
            drop_delivery = 1'b1;
          end else begin
            resync_wait   = 1'b0;
            drop_delivery = 1'b0;
          end
        end else begin
          drop_delivery = 1'b0;
        end
        r.delivery_skipped = drop_delivery;
      end
      MODE_BYTE: begin
        if (!drop_delivery) begin
          r.byte_in_frame = 1'b1;
          r.frame_offset  = frame_pos;
          if (frame_pos < HDR_LEN) begin
            if (frame_pos >= LEN_FIELD_LO) hdr_len = {hdr_len[23:0], w.data_byte};
            frame_pos = frame_pos + 32'd1;
            if (frame_pos == HDR_LEN) begin
              r.frame_length = hdr_len;
              if (hdr_len < HDR_LEN || (hdr_len > HDR_LEN && hdr_len > len_limit)) begin
                r.length_error = 1'b1;
                frame_pos      = '0;
                hdr_len        = '0;
                resync_wait    = 1'b1;
                drop_delivery  = 1'b1;
              end else if (hdr_len == HDR_LEN) begin
                r.frame_end = 1'b1;
                frame_pos   = '0;
                hdr_len     = '0;
              end
            end
          end else begin
            r.frame_length = hdr_len;
            frame_pos = frame_pos + 32'd1;
            if (frame_pos >= hdr_len) begin
              r.frame_end = 1'b1;
              frame_pos   = '0;
              hdr_len     = '0;
            end
          end
        end
      end
      MODE_LOSS: begin
        frame_pos     = '0;
        hdr_len       = '0;
        resync_wait   = 1'b1;
        drop_delivery = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    fail_count++;
    $display("%0t deframer mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    item_t   word;
    result_t got;
    result_t want;
    if (!rst_n) begin
      dir_orig      = 1'b1;
      len_limit     = MAX_LEN_RST;
      resync_wait   = 1'b1;
      first_seen    = 1'b0;
      drop_delivery = 1'b0;
      frame_pos     = '0;
      hdr_len       = '0;
      fail_count    = 0;
      results_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[CFG_ADDR_W-1:2] == REG_IS_ORIG) dir_orig = cfg_pwdata[0];
        else if (cfg_paddr[CFG_ADDR_W-1:2] == REG_MAX_LEN) len_limit = cfg_pwdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        word.mode                 = in_mon.mode;
        word.delivery_length      = in_mon.delivery_length;
        word.endpoint_established = in_mon.endpoint_established;
        word.had_gap              = in_mon.had_gap;
        word.signature_word       = in_mon.signature_word;
        word.data_byte            = in_mon.data_byte;
        results_due.push_back(deframe_word(word));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          note_mismatch("result word with nothing expected");
        end else begin
          want = results_due.pop_front();
          got.byte_in_frame    = out_mon.byte_in_frame;
          got.frame_offset     = out_mon.frame_offset;
          got.frame_end        = out_mon.frame_end;
          got.frame_length     = out_mon.frame_length;
          got.length_error     = out_mon.length_error;
          got.delivery_skipped = out_mon.delivery_skipped;
          check_field("byte_in_frame", 32'(got.byte_in_frame), 32'(want.byte_in_frame));
          check_field("frame_offset", got.frame_offset, want.frame_offset);
          check_field("frame_end", 32'(got.frame_end), 32'(want.frame_end));
          check_field("frame_length", got.frame_length, want.frame_length);
          check_field("length_error", 32'(got.length_error), 32'(want.length_error));
          check_field("delivery_skipped", 32'(got.delivery_skipped),
                      32'(want.delivery_skipped));
        end
      end
    end
    results_pending <= results_due.size();
  end

endmodule

@@ dv/tb_length_prefixed_frame_deframer_top.sv @@
// Testbench top: drives words, register writes and result stalls into the deframer and gives the verdict.
module tb_length_prefixed_frame_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfd_pkg::*;

  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [15:0] SIG_NONE     = 16'h1234;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned BODY_MAX     = 40;
  localparam int unsigned PHASE_WORDS  = 140;
  localparam int unsigned NUM_PHASES   = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  bit          in_steady = 1'b0;
  bit          out_steady = 1'b0;
  int unsigned ready_hold = 0;
  logic        orig_cfg = 1'b1;
  logic [31:0] max_cfg = MAX_LEN_RST;

  lpfd_in_if  in_ch();
  lpfd_out_if out_ch();

  length_prefixed_frame_deframer_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  deframer_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .fail_count      (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic item_t noise_word();
    item_t w;
    w.mode                 = 2'($urandom);
    w.delivery_length      = 16'($urandom);
    w.endpoint_established = 1'($urandom);
    w.had_gap              = 1'($urandom);
    w.signature_word       = 16'($urandom);
    w.data_byte            = 8'($urandom);
    return w;
  endfunction

  function automatic item_t byte_word(input logic [7:0] b);
    item_t w;
    w           = noise_word();
    w.mode      = MODE_BYTE;
    w.data_byte = b;
    return w;
  endfunction

  function automatic item_t mode_word(input logic [1:0] m);
    item_t w;
    w      = noise_word();
    w.mode = m;
    return w;
  endfunction

  function automatic item_t start_word(input logic [15:0] dlen, input logic estab,
                                       input logic gap, input logic [15:0] sig);
    item_t w;
    w                      = noise_word();
    w.mode                 = MODE_START;
    w.delivery_length      = dlen;
    w.endpoint_established = estab;
    w.had_gap              = gap;
    w.signature_word       = sig;
    return w;
  endfunction

  function automatic logic [15:0] min_delivery();
    return orig_cfg ? MIN_LEN_ORIG : MIN_LEN_RESP;
  endfunction

  function automatic logic [15:0] known_sig();
    logic [15:0] sigs [6];
    sigs = '{SIG_A, SIG_B, SIG_C, SIG_D, SIG_E, SIG_F};
    return sigs[$urandom_range(0, 5)];
  endfunction

  function automatic item_t good_start();
    logic [15:0] dlen;
    dlen = ($urandom_range(0, 4) == 0) ? min_delivery()
                                       : 16'($urandom_range(32'(min_delivery()), 65535));
    return start_word(dlen, 1'($urandom), 1'b0, known_sig());
  endfunction

  function automatic item_t bad_start();
    if ($urandom_range(0, 1) == 0)
      return start_word(16'($urandom_range(0, 32'(min_delivery()) - 1)), 1'($urandom),
                        1'b0, known_sig());
    return start_word(16'($urandom_range(32'(min_delivery()), 65535)), 1'($urandom),
                      1'b0, 16'($urandom));
  endfunction

  function automatic logic [31:0] good_len();
    logic [31:0] hi;
    hi = (max_cfg < BODY_MAX) ? max_cfg : 32'(BODY_MAX);
    return $urandom_range(HDR_LEN, hi);
  endfunction

  function automatic logic [31:0] bad_len();
    if (max_cfg == 32'hFFFF_FFFF || $urandom_range(0, 1) == 0)
      return $urandom_range(0, HDR_LEN - 32'd1);
    return $urandom_range(max_cfg + 32'd1, 32'hFFFF_FFFF);
  endfunction

  task automatic send_word(input item_t w);
    int unsigned gap;
    gap = pick_gap(in_steady);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid                <= 1'b1;
    in_ch.mode                 <= w.mode;
    in_ch.delivery_length      <= w.delivery_length;
    in_ch.endpoint_established <= w.endpoint_established;
    in_ch.had_gap              <= w.had_gap;
    in_ch.signature_word       <= w.signature_word;
    in_ch.data_byte            <= w.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // header bytes from index 'from' on, length field big-endian, then 'body' bytes
  task automatic send_frame(input logic [31:0] len, input int unsigned body,
                            input int unsigned from = 0);
    for (int unsigned i = from; i < HEADER_BYTES; i++) begin
      if (i >= LEN_FIELD_LO) send_word(byte_word(len[(LEN_FIELD_HI - 1 - i) * 8 +: 8]));
      else send_word(byte_word(8'($urandom)));
    end
    repeat (body) send_word(byte_word(8'($urandom)));
  endtask

  task automatic send_stray_bytes();
    repeat ($urandom_range(1, 4)) send_word(byte_word(8'($urandom)));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned roll;
    int unsigned body;
    logic [31:0] len;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) == 0) in_steady = !in_steady;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        send_word(good_start());
        repeat ($urandom_range(1, 3)) begin
          len = good_len();
          send_frame(len, len - HDR_LEN);
        end
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          send_frame(bad_len(), $urandom_range(0, 3));
        end else if (roll < 25) begin
          len  = ($urandom_range(0, 1) == 0) ? good_len() : $urandom_range(HDR_LEN, max_cfg);
          body = $urandom_range(0, 5);
          if (len - HDR_LEN <= body) body = 0;
          send_frame(len, body);
          if ($urandom_range(0, 1) == 0) send_word(mode_word(MODE_LOSS));
        end
      end else if (roll < 75) begin
        send_word(bad_start());
        send_stray_bytes();
      end else if (roll < 80) begin
        send_word(start_word(16'($urandom), 1'($urandom), 1'b1, known_sig()));
        send_stray_bytes();
      end else if (roll < 87) begin
        send_word(mode_word(MODE_LOSS));
        if ($urandom_range(0, 1) == 0) send_stray_bytes();
      end else if (roll < 90) begin
        send_word(mode_word(MODE_UNUSED));
      end else begin
        repeat ($urandom_range(1, 4)) send_word(noise_word());
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) out_steady = !out_steady;
      if (ready_hold != 0) ready_hold--;
      else if (!out_steady && $urandom_range(0, 2) == 0) ready_hold = pick_gap(1'b0);
      out_ch.ready <= (ready_hold == 0);
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic        orig_set [NUM_PHASES];
    logic [31:0] max_set [NUM_PHASES];
    orig_set = '{1'b0, 1'b1, 1'b0, 1'b1};
    max_set  = '{HDR_LEN, 32'hFFFF_FFFF, $urandom_range(HDR_LEN + 32'd1, 48), MAX_LEN_RST};

    rst_n                      <= 1'b0;
    cfg_psel                   <= 1'b0;
    cfg_penable                <= 1'b0;
    cfg_pwrite                 <= 1'b0;
    cfg_paddr                  <= '0;
    cfg_pwdata                 <= '0;
    in_ch.valid                <= 1'b0;
    in_ch.mode                 <= MODE_START;
    in_ch.delivery_length      <= '0;
    in_ch.endpoint_established <= 1'b0;
    in_ch.had_gap              <= 1'b0;
    in_ch.signature_word       <= '0;
    in_ch.data_byte            <= '0;
    out_ch.ready               <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // byte ahead of any delivery, then first delivery while not established
    send_word(byte_word(8'hFF));
    send_word(start_word(16'd0, 1'b0, 1'b0, 16'h0000));
    send_frame(HDR_LEN, 0, 1);
    // resync checks on an empty buffer
    send_word(start_word(MIN_LEN_ORIG - 16'd1, 1'b1, 1'b0, SIG_A));
    send_word(byte_word(8'h00));
    send_word(start_word(MIN_LEN_ORIG, 1'b1, 1'b0, SIG_NONE));
    send_word(start_word(MIN_LEN_ORIG, 1'b1, 1'b1, SIG_B));
    send_word(start_word(MIN_LEN_ORIG, 1'b1, 1'b0, SIG_C));
    // length below header size, then the rest of the delivery is dropped
    send_frame(HDR_LEN - 32'd1, 0);
    send_word(byte_word(8'hA5));
    send_word(mode_word(MODE_LOSS));
    send_word(mode_word(MODE_UNUSED));
    send_word(start_word(16'hFFFF, 1'b0, 1'b0, SIG_F));
    run_random(PHASE_WORDS - 20);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      drain();
      orig_cfg = orig_set[p];
      max_cfg  = max_set[p];
      write_reg(REG_IS_ORIG, 32'(orig_cfg));
      write_reg(REG_MAX_LEN, max_cfg);
      run_random(PHASE_WORDS);
    end

    drain();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ length_prefixed_frame_deframer_top.f @@
rtl/core/lpfd_pkg.sv
rtl/core/lpfd_in_if.sv
rtl/core/lpfd_out_if.sv
rtl/core/lpfd_cfg_regs.sv
rtl/core/lpfd_in_stage.sv
rtl/core/lpfd_core.sv
rtl/core/lpfd_out_stage.sv
rtl/core/length_prefixed_frame_deframer_top.sv
rtl/core/lpfd_checker.sv
dv/deframer_checker.sv
dv/tb_length_prefixed_frame_deframer_top.sv
